// ----- hdl/mtf_pkg.sv -----
package mtf_pkg;

	// Field widths and the default list length.
	localparam int SYM_W             = 8;
	localparam int ALPHABET_SIZE_DEF = 256;

	typedef logic [SYM_W-1:0] sym_t;

	// Configuration register indexes.
	localparam logic CFG_VARIANT   = 1'b0;
	localparam logic CFG_DIRECTION = 1'b1;

	// Variant codes; the unused code behaves as plain move-to-front.
	localparam logic [1:0] VAR_MTF   = 2'd0;
	localparam logic [1:0] VAR_MTF1  = 2'd1;
	localparam logic [1:0] VAR_MTF2  = 2'd2;
	localparam logic [1:0] VAR_SPARE = 2'd3;

	// Direction codes.
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Reset value of the last moved symbol.
	localparam sym_t PREV_RESET = sym_t'(1);

	// Update command broadcast to every cell of the list.
	typedef struct packed {
		logic shift; // move the entry at pos up to dest
		logic clear; // return the list to identity
		logic dest;  // destination position, head or position 1
		sym_t pos;   // position the entry is taken from
		sym_t sym;   // symbol written at dest
	} move_cmd_t;

endpackage

// ----- hdl/mtf_cell.sv -----
module mtf_cell #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mtf_pkg::move_cmd_t cmd,
	input  mtf_pkg::sym_t     key,
	input  mtf_pkg::sym_t     prev_entry,
	output mtf_pkg::sym_t     entry,
	output logic              hit,
	output mtf_pkg::sym_t     rd
);
	import mtf_pkg::*;

	localparam sym_t IDX = sym_t'(INDEX);

	sym_t entry_q;
	logic in_range;

	// Search side: match on the symbol, or hand out the entry when the key names this place.
	assign hit   = (entry_q == key);
	assign rd    = (IDX == key) ? entry_q : '0;
	assign entry = entry_q;

	// This cell takes its neighbour's entry when it lies between dest and pos.
	assign in_range = (IDX > sym_t'(cmd.dest)) && (IDX <= cmd.pos);

	// Entry update: block end wins over any move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= IDX;
		end else if (cmd.clear) begin
			entry_q <= IDX;
		end else if (cmd.shift && (IDX == sym_t'(cmd.dest))) begin
			entry_q <= cmd.sym;
		end else if (cmd.shift && in_range) begin
			entry_q <= prev_entry;
		end
	end

endmodule

// ----- hdl/move_to_front_codec_top.sv -----
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_byte, last_in_block
// out       out_valid / out_stall out_byte, block_end
// cfg       cfg_we               cfg_index, cfg_data
//
// For each item, the accept edge registers the parallel search over all cells,
// and a later edge moves the entry through the cell row and loads the output register.
// The update waits while a finished item sits unclaimed in the output register.
// After reset the list holds identity and the last moved symbol is one; no clearing pass.
// in_stall stays high from the accept edge until the list update has been made.
module move_to_front_codec_top #(
	parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [1:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  mtf_pkg::sym_t in_byte,
	input  logic          last_in_block,
	output logic          out_valid,
	input  logic          out_stall,
	output mtf_pkg::sym_t out_byte,
	output logic          block_end
);
	import mtf_pkg::*;

	logic [1:0] variant_q;
	logic       direction_q;
	sym_t       prev_q;
	logic       pend_q;
	logic       out_valid_q;
	sym_t       out_byte_q;
	logic       block_end_q;

	sym_t       pos_s1;
	sym_t       sym_s1;
	sym_t       res_s1;
	logic       found_s1;
	logic       last_s1;

	logic [ALPHABET_SIZE-1:0] hit;
	sym_t       entry [ALPHABET_SIZE];
	sym_t       rd    [ALPHABET_SIZE];

	sym_t       hit_pos;
	sym_t       rd_sym;
	logic       hit_any;
	logic       rank_ok;
	logic       accept;
	logic       apply;
	logic       move;
	logic       dest;
	move_cmd_t  cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q   <= VAR_MTF;
			direction_q <= DIR_ENCODE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VARIANT:   variant_q   <= cfg_data;
				CFG_DIRECTION: direction_q <= cfg_data[0];
				default:       variant_q   <= variant_q;
			endcase
		end
	end

	// Row of list cells.
	for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
		mtf_cell #(.INDEX(k)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (in_byte),
			.prev_entry ((k == 0) ? entry[0] : entry[(k == 0) ? 0 : k - 1]),
			.entry      (entry[k]),
			.hit        (hit[k]),
			.rd         (rd[k])
		);
	end

	// Collect the cell outputs: the matching position and the addressed entry.
	always_comb begin
		hit_pos = '0;
		rd_sym  = '0;
		for (int k = 0; k < ALPHABET_SIZE; k++) begin
			if (hit[k]) begin
				hit_pos = hit_pos | sym_t'(k);
			end
			rd_sym = rd_sym | rd[k];
		end
	end

	assign hit_any = |hit;
	assign rank_ok = ({1'b0, in_byte} < (SYM_W + 1)'(ALPHABET_SIZE));

	// Handshake control.
	assign accept    = in_valid && !pend_q;
	assign apply     = pend_q && (!out_valid_q || !out_stall);
	assign in_stall  = pend_q;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign block_end = block_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_q <= 1'b1;
			end else if (apply) begin
				pend_q <= 1'b0;
			end
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search results captured at the accept edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last_in_block;
			if (direction_q == DIR_ENCODE) begin
				found_s1 <= hit_any;
				pos_s1   <= hit_pos;
				sym_s1   <= in_byte;
				res_s1   <= hit_any ? hit_pos : in_byte;
			end else begin
				found_s1 <= rank_ok;
				pos_s1   <= in_byte;
				sym_s1   <= rd_sym;
				res_s1   <= rank_ok ? rd_sym : in_byte;
			end
		end
	end

	// Where the coded symbol goes, by variant.
	always_comb begin
		move = 1'b0;
		dest = 1'b0;
		case (variant_q)
			VAR_MTF1: begin
				if (pos_s1 == sym_t'(1)) begin
					move = 1'b1;
				end else if (pos_s1 > sym_t'(1)) begin
					move = 1'b1;
					dest = 1'b1;
				end
			end
			VAR_MTF2: begin
				if (pos_s1 == sym_t'(1)) begin
					move = (prev_q == entry[0]);
				end else if (pos_s1 > sym_t'(1)) begin
					move = 1'b1;
					dest = 1'b1;
				end
			end
			default: begin
				move = (pos_s1 != '0);
			end
		endcase
	end

	always_comb begin
		cmd.shift = apply && found_s1 && move;
		cmd.clear = apply && last_s1;
		cmd.dest  = dest;
		cmd.pos   = pos_s1;
		cmd.sym   = sym_s1;
	end

	// Last moved symbol, written by the MTF2 variant only, and set back to one at a block end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= PREV_RESET;
		end else if (apply) begin
			if (last_s1) begin
				prev_q <= PREV_RESET;
			end else if (found_s1 && (variant_q == VAR_MTF2)) begin
				prev_q <= sym_s1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (apply) begin
			out_byte_q  <= res_s1;
			block_end_q <= last_s1;
		end
	end

endmodule

// ----- hdl/mtf_checker.sv -----
module mtf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input mtf_pkg::sym_t out_byte,
	input logic          block_end
);

	// An accepted item keeps the input side busy for its update cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again before the list update");

	// With the output register free, a pending item completes in the next cycle.
	a_update_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !out_valid) |=> (!in_stall && out_valid))
		else $error("pending item did not complete");

	// A result only appears after an item was pending.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an accepted item");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(block_end)))
		else $error("stalled result changed");

endmodule

bind move_to_front_codec_top mtf_checker u_mtf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.block_end (block_end)
);

// ----- tb/move_to_front_codec_top_test.sv -----
module move_to_front_codec_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mtf_pkg::*;

	localparam int ALPHA = ALPHABET_SIZE_DEF;

	// One result item as the output channel presents it.
	typedef struct packed {
		sym_t code;
		logic closes;
	} out_item_t;

	// One row of the directed table: an optional settings change, then one item.
	typedef struct {
		logic       reconf;
		logic [1:0] vmode;
		logic       dmode;
		sym_t       data;
		logic       last;
		logic       known;
		sym_t       result;
	} vec_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [1:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	sym_t       in_byte;
	logic       last_in_block;
	logic       out_valid;
	logic       out_stall;
	sym_t       out_byte;
	logic       block_end;

	// Mirror of the coder: list order, last coded symbol and the two settings.
	sym_t       sym_order [ALPHA];
	sym_t       last_moved;
	logic [1:0] cur_variant;
	logic       cur_dir;

	out_item_t  pending_out[$];
	out_item_t  got_item;
	int         fail_count;
	int         snd_idle_pct;
	int         rcv_stall_pct;
	logic       hold_req;
	logic       hold_ack;
	int         hold_left;

	localparam int NVEC = 23;
	vec_t dir_vec [NVEC] = '{
		'{1'b1, VAR_MTF,   DIR_ENCODE, 8'd0,   1'b0, 1'b1, 8'd0},
		'{1'b0, VAR_MTF,   DIR_ENCODE, 8'd255, 1'b0, 1'b1, 8'd255},
		'{1'b0, VAR_MTF,   DIR_ENCODE, 8'd0,   1'b0, 1'b0, 8'd0},
		'{1'b0, VAR_MTF,   DIR_ENCODE, 8'd128, 1'b1, 1'b0, 8'd0},
		'{1'b0, VAR_MTF,   DIR_ENCODE, 8'd1,   1'b0, 1'b1, 8'd1},
		'{1'b1, VAR_MTF1,  DIR_ENCODE, 8'd5,   1'b0, 1'b1, 8'd5},
		'{1'b0, VAR_MTF1,  DIR_ENCODE, 8'd5,   1'b0, 1'b0, 8'd0},
		'{1'b0, VAR_MTF1,  DIR_ENCODE, 8'd255, 1'b1, 1'b0, 8'd0},
		'{1'b1, VAR_MTF2,  DIR_ENCODE, 8'd1,   1'b0, 1'b1, 8'd1},
		'{1'b0, VAR_MTF2,  DIR_ENCODE, 8'd0,   1'b0, 1'b1, 8'd0},
		'{1'b0, VAR_MTF2,  DIR_ENCODE, 8'd1,   1'b0, 1'b1, 8'd1},
		'{1'b0, VAR_MTF2,  DIR_ENCODE, 8'd9,   1'b0, 1'b1, 8'd9},
		'{1'b0, VAR_MTF2,  DIR_ENCODE, 8'd9,   1'b1, 1'b0, 8'd0},
		'{1'b1, VAR_SPARE, DIR_DECODE, 8'd0,   1'b0, 1'b1, 8'd0},
		'{1'b0, VAR_SPARE, DIR_DECODE, 8'd255, 1'b0, 1'b1, 8'd255},
		'{1'b0, VAR_SPARE, DIR_DECODE, 8'd1,   1'b0, 1'b0, 8'd0},
		'{1'b0, VAR_SPARE, DIR_DECODE, 8'd255, 1'b1, 1'b0, 8'd0},
		'{1'b1, VAR_MTF,   DIR_DECODE, 8'd200, 1'b0, 1'b1, 8'd200},
		'{1'b0, VAR_MTF,   DIR_DECODE, 8'd0,   1'b1, 1'b0, 8'd0},
		'{1'b1, VAR_MTF1,  DIR_DECODE, 8'd1,   1'b0, 1'b1, 8'd1},
		'{1'b0, VAR_MTF1,  DIR_DECODE, 8'd2,   1'b0, 1'b0, 8'd0},
		'{1'b1, VAR_MTF2,  DIR_DECODE, 8'd1,   1'b0, 1'b0, 8'd0},
		'{1'b0, VAR_MTF2,  DIR_DECODE, 8'd255, 1'b1, 1'b0, 8'd0}
	};

	move_to_front_codec_top #(
		.ALPHABET_SIZE(ALPHA)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.last_in_block(last_in_block),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.block_end    (block_end)
	);

	// Free-running clock with a 10 ns period.
	always #5 clk = ~clk;

	// Put the list back in natural order, as after reset or a block end.
	function automatic void restore_identity();
		for (int k = 0; k < ALPHA; k++) begin
			sym_order[k] = sym_t'(k);
		end
		last_moved = PREV_RESET;
	endfunction

	// Take the entry at position src out and insert it at dst, pushing the rest down.
	function automatic void lift_entry(int src, int dst);
		sym_t s;
		s = sym_order[src];
		for (int k = src; k > dst; k--) begin
			sym_order[k] = sym_order[k-1];
		end
		sym_order[dst] = s;
	endfunction

	// Reorder the list after the entry at pos has been coded.
	function automatic void apply_move(int pos);
		sym_t s;
		s = sym_order[pos];
		case (cur_variant)
			VAR_MTF1: begin
				if (pos == 1)
					lift_entry(1, 0);
				else if (pos > 1)
					lift_entry(pos, 1);
			end
			VAR_MTF2: begin
				// Promotion to the head needs the head to be the last symbol coded.
				if (pos == 1) begin
					if (last_moved == sym_order[0])
						lift_entry(1, 0);
				end else if (pos > 1) begin
					lift_entry(pos, 1);
				end
				last_moved = s;
			end
			default: begin
				if (pos > 0)
					lift_entry(pos, 0);
			end
		endcase
	endfunction

	// Code one item and update the list; returns the expected output byte.
	function automatic sym_t mtf_code(sym_t data, logic last_flag);
		sym_t res;
		int   pos;
		res = data;
		pos = -1;
		if (cur_dir == DIR_ENCODE) begin
			for (int k = ALPHA - 1; k >= 0; k--) begin
				if (sym_order[k] == data)
					pos = k;
			end
		end else begin
			pos = int'(data);
		end
		if (pos >= 0 && pos < ALPHA) begin
			res = (cur_dir == DIR_ENCODE) ? sym_t'(pos) : sym_order[pos];
			apply_move(pos);
		end
		if (last_flag)
			restore_identity();
		return res;
	endfunction

	// Mostly symbols or ranks near the head, where the variants differ; some near the tail, some anywhere.
	function automatic sym_t pick_data();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return sym_t'($urandom_range(0, 255));
		else if (r == 3)
			return (cur_dir == DIR_ENCODE) ? sym_order[$urandom_range(ALPHA - 8, ALPHA - 1)]
			                               : sym_t'($urandom_range(ALPHA - 8, ALPHA - 1));
		else
			return (cur_dir == DIR_ENCODE) ? sym_order[$urandom_range(0, 3)]
			                               : sym_t'($urandom_range(0, 3));
	endfunction

	// Offer one item, wait for it to be taken and record the expected result.
	// Called and returns at a falling edge.
	task automatic offer_item(input sym_t data, input logic last_flag, input logic known,
	                          input sym_t typed);
		sym_t pred;
		while (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= data;
		last_in_block <= last_flag;
		do
			@(posedge clk);
		while (in_stall);
		pred = mtf_code(data, last_flag);
		pending_out.push_back('{known ? typed : pred, last_flag});
		@(negedge clk);
	endtask

	// Let the block drain, then write both settings registers.
	task automatic write_settings(input logic [1:0] vmode, input logic dmode);
		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_VARIANT;
		cfg_data  <= vmode;
		@(negedge clk);
		cfg_index <= CFG_DIRECTION;
		cfg_data  <= {1'($urandom_range(0, 1)), dmode};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_variant = vmode;
		cur_dir     = dmode;
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = 60;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (rcv_stall_pct != 0 && $urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	// Compare every accepted output item with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out.size() == 0) begin
				$error("output item with nothing expected: out_byte %0d block_end %0b",
				       out_byte, block_end);
				fail_count++;
			end else begin
				got_item = pending_out.pop_front();
				if (out_byte !== got_item.code) begin
					$error("out_byte: expected %0d, actual %0d", got_item.code, out_byte);
					fail_count++;
				end
				if (block_end !== got_item.closes) begin
					$error("block_end: expected %0b, actual %0b", got_item.closes, block_end);
					fail_count++;
				end
			end
		end
	end

	// Guard against a hang.
	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	// Main sequence: reset, directed table, then random phases.
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_VARIANT;
		cfg_data      = 2'd0;
		in_valid      = 1'b0;
		in_byte       = '0;
		last_in_block = 1'b0;
		out_stall     = 1'b0;
		fail_count    = 0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		hold_req      = 1'b0;
		hold_ack      = 1'b0;
		hold_left     = 0;
		cur_variant   = VAR_MTF;
		cur_dir       = DIR_ENCODE;
		restore_identity();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, without idling.
		for (int i = 0; i < NVEC; i++) begin
			if (dir_vec[i].reconf)
				write_settings(dir_vec[i].vmode, dir_vec[i].dmode);
			offer_item(dir_vec[i].data, dir_vec[i].last, dir_vec[i].known, dir_vec[i].result);
		end

		// Random phases over all settings and idling patterns.
		for (int p = 0; p < 8; p++) begin
			case ((p + p / 4) % 4)
				0: begin
					snd_idle_pct  = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					snd_idle_pct  = 52;
					rcv_stall_pct = 0;
				end
				2: begin
					snd_idle_pct  = 0;
					rcv_stall_pct = 52;
				end
				default: begin
					snd_idle_pct  = 18;
					rcv_stall_pct = 18;
				end
			endcase
			write_settings(2'(p % 4), 1'(p / 4));
			// Back up the output while the sender keeps offering.
			if (p == 4)
				hold_req <= ~hold_req;
			for (int i = 0; i < 210; i++)
				offer_item(pick_data(), $urandom_range(0, 11) == 0, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fail_count == 0 && pending_out.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mtf_pkg.sv
hdl/mtf_cell.sv
hdl/move_to_front_codec_top.sv
hdl/mtf_checker.sv
tb/move_to_front_codec_top_test.sv
